@@ rtl/mpc_pkg.sv @@
// ---------------------------------------------------------------------------
// mpc_pkg: shared types and constants
// Widths, codes and the entry and control types of the max-plus closure unit.
// ---------------------------------------------------------------------------
package mpc_pkg;

   localparam int NODE_COUNT = 16;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int VAL_W      = 40;
   localparam int WGT_W      = 32;
   localparam int TOL_W      = 16;
   localparam int SUM_W      = VAL_W + 2;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_EDGE  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] STS_APPLIED   = 2'd0;
   localparam logic [1:0] STS_IMPLIED   = 2'd1;
   localparam logic [1:0] STS_CYCLE     = 2'd2;
   localparam logic [1:0] STS_DONE      = 2'd3;

   // One closure entry: reachable mark and value
   typedef struct packed {
      logic                    ok;
      logic signed [VAL_W-1:0] val;
   } entry_type;

   // Broadcast control from the sequencer to every row cell
   typedef struct packed {
      logic                    shift;
      logic                    clear;
      logic                    cap_au;
      logic                    apply;
      logic signed [WGT_W-1:0] weight;
      entry_type               vb;
   } cell_ctrl_type;

endpackage

@@ rtl/max_plus_closure_edge_insert_unit.sv @@
// ---------------------------------------------------------------------------
// max_plus_closure_edge_insert_unit: incremental longest-path closure
// Keeps an all-pairs max-plus closure in a column of row cells and runs
// clear, edge insert and entry read commands.
// ---------------------------------------------------------------------------
// Sequence, from accept to the strobe: clear passes through ST_CLEAR; read
// runs one ring sweep in ST_READ; an edge runs the ST_CHECK sweep and ST_DECIDE,
// and an edge that is neither implied nor cyclic then runs the ST_APPLY sweep; a
// spare action answers straight from idle. Throughput: one command at a time; a
// ring sweep passes one column of every row per cycle. The strobe cycle overlaps the next accept.
// Reset: identity closure, tolerance 1, idle. Results are never stalled.
module max_plus_closure_edge_insert_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic [mpc_pkg::IDX_W-1:0]            req_from_node,
   input  logic [mpc_pkg::IDX_W-1:0]            req_to_node,
   input  logic signed [mpc_pkg::WGT_W-1:0]     req_edge_weight,
   input  logic                                 csr_wr_en,
   input  logic [mpc_pkg::TOL_W-1:0]            csr_wr_data,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic signed [mpc_pkg::VAL_W-1:0]     rsp_path_value,
   output logic                                 rsp_path_known,
   output logic                                 rsp_saturated
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_CHECK, ST_DECIDE, ST_APPLY, ST_READ
   } state_type;

   state_type                        state_ff;
   logic [mpc_pkg::IDX_W-1:0]        step_ff;
   logic [mpc_pkg::IDX_W-1:0]        from_ff;
   logic [mpc_pkg::IDX_W-1:0]        to_ff;
   logic signed [mpc_pkg::WGT_W-1:0] weight_ff;
   logic                             nodes_ok_ff;
   mpc_pkg::entry_type               uv_ff;
   mpc_pkg::entry_type               vu_ff;
   logic                             clip_ff;
   logic [mpc_pkg::TOL_W-1:0]        tol_ff;
   logic                             rsp_valid_ff;
   logic [1:0]                       rsp_status_ff;
   logic signed [mpc_pkg::VAL_W-1:0] rsp_value_ff;
   logic                             rsp_known_ff;
   logic                             rsp_sat_ff;

   mpc_pkg::entry_type               heads [mpc_pkg::NODE_COUNT];
   logic [mpc_pkg::NODE_COUNT-1:0]   clips;
   mpc_pkg::cell_ctrl_type           ctrl;

   logic                             accept;
   logic                             last_step;
   logic                             nodes_ok;
   logic signed [mpc_pkg::SUM_W-1:0] w_ext;
   logic signed [mpc_pkg::SUM_W-1:0] tol_ext;
   logic                             redundant;
   logic                             cyclic;

   assign busy           = state_ff != ST_IDLE;
   assign accept         = start && !busy;
   assign last_step      = step_ff == {mpc_pkg::IDX_W{1'b1}};
   assign nodes_ok       = (32'(req_from_node) < mpc_pkg::NODE_COUNT)
                        && (32'(req_to_node) < mpc_pkg::NODE_COUNT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_path_value = rsp_value_ff;
   assign rsp_path_known = rsp_known_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // Redundancy and positive-cycle tests on the captured entries
   always_comb begin
      w_ext     = mpc_pkg::SUM_W'(weight_ff);
      tol_ext   = mpc_pkg::SUM_W'({1'b0, tol_ff});
      redundant = uv_ff.ok && (w_ext <= mpc_pkg::SUM_W'(uv_ff.val) + tol_ext);
      cyclic    = vu_ff.ok && (mpc_pkg::SUM_W'(vu_ff.val) + w_ext > tol_ext);
   end

   // Drive the row cells
   always_comb begin
      ctrl.shift  = (state_ff == ST_CHECK) || (state_ff == ST_APPLY)
                 || (state_ff == ST_READ);
      ctrl.clear  = state_ff == ST_CLEAR;
      ctrl.cap_au = (state_ff == ST_CHECK) && (step_ff == from_ff);
      ctrl.apply  = state_ff == ST_APPLY;
      ctrl.weight = weight_ff;
      ctrl.vb     = heads[to_ff];
   end

   for (genvar g = 0; g < mpc_pkg::NODE_COUNT; g++) begin : g_row
      mpc_row_cell u_row (
         .clock  (clock),
         .reset  (reset),
         .row_id (mpc_pkg::IDX_W'(g)),
         .ctrl   (ctrl),
         .head   (heads[g]),
         .clip   (clips[g])
      );
   end

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= mpc_pkg::TOL_W'(1);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // Sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (accept) begin
                  from_ff     <= req_from_node;
                  to_ff       <= req_to_node;
                  weight_ff   <= req_edge_weight;
                  nodes_ok_ff <= nodes_ok;
                  clip_ff     <= 1'b0;
                  rsp_value_ff <= '0;
                  rsp_known_ff <= 1'b0;
                  rsp_sat_ff   <= 1'b0;
                  case (req_action)
                     mpc_pkg::ACT_CLEAR: state_ff <= ST_CLEAR;
                     mpc_pkg::ACT_EDGE: begin
                        if (nodes_ok) begin
                           state_ff <= ST_CHECK;
                        end else begin
                           rsp_status_ff <= mpc_pkg::STS_IMPLIED;
                           rsp_valid_ff  <= 1'b1;
                        end
                     end
                     mpc_pkg::ACT_READ: state_ff <= ST_READ;
                     default: begin
                        rsp_status_ff <= mpc_pkg::STS_DONE;
                        rsp_valid_ff  <= 1'b1;
                     end
                  endcase
               end
            end
            ST_CLEAR: begin
               rsp_status_ff <= mpc_pkg::STS_DONE;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            ST_CHECK: begin
               // capture D(u,v) and D(v,u) as the columns pass
               if (step_ff == to_ff) begin
                  uv_ff <= heads[from_ff];
               end
               if (step_ff == from_ff) begin
                  vu_ff <= heads[to_ff];
               end
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (redundant) begin
                  rsp_status_ff <= mpc_pkg::STS_IMPLIED;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else if (cyclic) begin
                  rsp_status_ff <= mpc_pkg::STS_CYCLE;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               clip_ff <= clip_ff || (|clips);
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  rsp_status_ff <= mpc_pkg::STS_APPLIED;
                  rsp_sat_ff    <= clip_ff || (|clips);
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_READ: begin
               if (step_ff == to_ff && nodes_ok_ff && heads[from_ff].ok) begin
                  rsp_value_ff <= heads[from_ff].val;
                  rsp_known_ff <= 1'b1;
               end
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  rsp_status_ff <= mpc_pkg::STS_DONE;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Rings stay column-aligned whenever the sequencer is idle
   a_aligned_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == '0))
      else $error("ring not aligned while idle");

   // Clipping is only reported for an applied edge
   a_sat_applied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_status == mpc_pkg::STS_APPLIED))
      else $error("saturated flag on a non-applied result");

   // A reachable entry is only reported by a read
   a_known_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_path_known) |-> (rsp_status == mpc_pkg::STS_DONE))
      else $error("path_known on a non-read result");

   // An applied edge comes out of the apply sweep
   a_apply_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mpc_pkg::STS_APPLIED)
      |-> ($past(state_ff) == ST_APPLY))
      else $error("applied result without an apply sweep");

endmodule

@@ rtl/mpc_row_cell.sv @@
// ---------------------------------------------------------------------------
// mpc_row_cell: one closure row
// Holds one row as a ring of entries that pass to their neighbor on every
// shift, and raises the head entry during an edge sweep.
// ---------------------------------------------------------------------------
module mpc_row_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mpc_pkg::IDX_W-1:0]     row_id,
   input  mpc_pkg::cell_ctrl_type        ctrl,
   output mpc_pkg::entry_type            head,
   output logic                          clip
);

   mpc_pkg::entry_type row_ff [mpc_pkg::NODE_COUNT];
   mpc_pkg::entry_type au_ff;
   mpc_pkg::entry_type new_head;

   logic signed [mpc_pkg::SUM_W-1:0] sum;
   logic signed [mpc_pkg::VAL_W-1:0] sat;
   logic                             both_ok;
   logic                             over_hi;
   logic                             over_lo;
   logic                             take;

   assign head = row_ff[0];

   // Form old(a,u) + w + old(v,b), clip to range, keep the larger
   always_comb begin
      sum = mpc_pkg::SUM_W'(au_ff.val) + mpc_pkg::SUM_W'(ctrl.weight)
          + mpc_pkg::SUM_W'(ctrl.vb.val);
      over_hi = sum > $signed({{(mpc_pkg::SUM_W-mpc_pkg::VAL_W+1){1'b0}},
                               {(mpc_pkg::VAL_W-1){1'b1}}});
      over_lo = sum < $signed({{(mpc_pkg::SUM_W-mpc_pkg::VAL_W+1){1'b1}},
                               {(mpc_pkg::VAL_W-1){1'b0}}});
      if (over_hi) begin
         sat = {1'b0, {(mpc_pkg::VAL_W-1){1'b1}}};
      end else if (over_lo) begin
         sat = {1'b1, {(mpc_pkg::VAL_W-1){1'b0}}};
      end else begin
         sat = sum[mpc_pkg::VAL_W-1:0];
      end
      both_ok = ctrl.apply && au_ff.ok && ctrl.vb.ok;
      take    = both_ok && (!row_ff[0].ok || sat > row_ff[0].val);
      clip    = both_ok && (over_hi || over_lo);
      if (take) begin
         new_head.ok  = 1'b1;
         new_head.val = sat;
      end else begin
         new_head = row_ff[0];
      end
   end

   // Rotate the row ring, or restore the identity row
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int k = 0; k < mpc_pkg::NODE_COUNT; k++) begin
            row_ff[k].ok  <= (mpc_pkg::IDX_W'(k) == row_id);
            row_ff[k].val <= '0;
         end
      end else if (ctrl.shift) begin
         for (int k = 0; k < mpc_pkg::NODE_COUNT - 1; k++) begin
            row_ff[k] <= row_ff[k+1];
         end
         row_ff[mpc_pkg::NODE_COUNT-1] <= new_head;
      end
   end

   // Hold old(a,u) for the apply sweep
   always_ff @(posedge clock) begin
      if (ctrl.cap_au) begin
         au_ff <= row_ff[0];
      end
   end

endmodule

@@ sim/max_plus_closure_edge_insert_unit_tb.sv @@
// ---------------------------------------------------------------------------
// max_plus_closure_edge_insert_unit_tb: self-checking closure unit bench
// Drives clear, edge insert, read and spare commands and tolerance writes in
// random bursts, predicts each response from a behavioral copy of the closure
// matrix and compares every field of every response in order.
// ---------------------------------------------------------------------------
module max_plus_closure_edge_insert_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CELLS       = mpc_pkg::NODE_COUNT * mpc_pkg::NODE_COUNT;
   localparam int  IDLE_LIMIT  = 20000;
   localparam int  RANDOM_CMDS = 1650;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam logic signed [mpc_pkg::VAL_W-1:0] VAL_HI =
      {1'b0, {(mpc_pkg::VAL_W-1){1'b1}}};
   localparam logic signed [mpc_pkg::VAL_W-1:0] VAL_LO =
      {1'b1, {(mpc_pkg::VAL_W-1){1'b0}}};

   typedef struct {
      logic [1:0]                       action;
      logic [mpc_pkg::IDX_W-1:0]        from_node;
      logic [mpc_pkg::IDX_W-1:0]        to_node;
      logic signed [mpc_pkg::WGT_W-1:0] weight;
      bit                               is_cfg;
      logic [mpc_pkg::TOL_W-1:0]        cfg_value;
      bit                               drain;
   } command_type;

   typedef struct {
      logic [1:0]                       status;
      logic signed [mpc_pkg::VAL_W-1:0] value;
      logic                             known;
      logic                             saturated;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [mpc_pkg::IDX_W-1:0] req_from_node = '0;
   logic [mpc_pkg::IDX_W-1:0] req_to_node = '0;
   logic signed [mpc_pkg::WGT_W-1:0] req_edge_weight = '0;
   logic csr_wr_en = 1'b0;
   logic [mpc_pkg::TOL_W-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [mpc_pkg::VAL_W-1:0] rsp_path_value;
   logic rsp_path_known;
   logic rsp_saturated;

   max_plus_closure_edge_insert_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_from_node(req_from_node),
      .req_to_node(req_to_node), .req_edge_weight(req_edge_weight),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_path_value(rsp_path_value), .rsp_path_known(rsp_path_known),
      .rsp_saturated(rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // closure copy and tolerance used for prediction
   logic signed [mpc_pkg::VAL_W-1:0] path_len[CELLS];
   logic                             path_ok[CELLS];
   logic [mpc_pkg::TOL_W-1:0]        tol_now;

   command_type  pending_cmds[$];
   response_type expected_rsps[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;

   function automatic void add_cmd(command_type c);
      pending_cmds = {pending_cmds, c};
   endfunction

   function automatic void restore_identity();
      for (int i = 0; i < CELLS; i++) begin
         path_len[i] = '0;
         path_ok[i]  = (i % (mpc_pkg::NODE_COUNT + 1)) == 0;
      end
   endfunction

   // compute the response of one command and update the closure copy
   function automatic response_type closure_response(command_type c);
      response_type r;
      logic signed [mpc_pkg::VAL_W-1:0] old_len[CELLS];
      logic                             old_ok[CELLS];
      logic signed [mpc_pkg::SUM_W-1:0] s, tol, w;
      int uv, vu, u, v;
      r = '{mpc_pkg::STS_DONE, '0, 1'b0, 1'b0};
      u = c.from_node;
      v = c.to_node;
      uv = u * mpc_pkg::NODE_COUNT + v;
      vu = v * mpc_pkg::NODE_COUNT + u;
      tol = $signed({1'b0, tol_now});
      w = c.weight;
      case (c.action)
         mpc_pkg::ACT_CLEAR: restore_identity();
         mpc_pkg::ACT_EDGE: begin
            if (path_ok[uv] && w <= path_len[uv] + tol)
               r.status = mpc_pkg::STS_IMPLIED;
            else if (path_ok[vu] && path_len[vu] + w > tol)
               r.status = mpc_pkg::STS_CYCLE;
            else begin
               r.status = mpc_pkg::STS_APPLIED;
               old_len = path_len;
               for (int i = 0; i < CELLS; i++) old_ok[i] = path_ok[i];
               for (int a = 0; a < mpc_pkg::NODE_COUNT; a++) begin
                  if (old_ok[a * mpc_pkg::NODE_COUNT + u]) begin
                     for (int b = 0; b < mpc_pkg::NODE_COUNT; b++) begin
                        if (old_ok[v * mpc_pkg::NODE_COUNT + b]) begin
                           s = old_len[a * mpc_pkg::NODE_COUNT + u] + w
                               + old_len[v * mpc_pkg::NODE_COUNT + b];
                           if (s > VAL_HI) begin
                              s = VAL_HI;
                              r.saturated = 1'b1;
                           end
                           if (s < VAL_LO) begin
                              s = VAL_LO;
                              r.saturated = 1'b1;
                           end
                           if (!path_ok[a * mpc_pkg::NODE_COUNT + b]
                               || s > path_len[a * mpc_pkg::NODE_COUNT + b]) begin
                              path_len[a * mpc_pkg::NODE_COUNT + b] =
                                 s[mpc_pkg::VAL_W-1:0];
                              path_ok[a * mpc_pkg::NODE_COUNT + b] = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
         end
         mpc_pkg::ACT_READ: begin
            if (path_ok[uv]) begin
               r.known = 1'b1;
               r.value = path_len[uv];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic command_type make_cmd(logic [1:0] act, int f, int t,
                                           logic signed [mpc_pkg::WGT_W-1:0] w);
      command_type c;
      c = '{act, f[mpc_pkg::IDX_W-1:0], t[mpc_pkg::IDX_W-1:0], w, 1'b0, '0, 1'b0};
      return c;
   endfunction

   function automatic command_type make_cfg(logic [mpc_pkg::TOL_W-1:0] value);
      command_type c;
      c = '{mpc_pkg::ACT_CLEAR, '0, '0, '0, 1'b1, value, 1'b1};
      return c;
   endfunction

   function automatic logic signed [mpc_pkg::WGT_W-1:0] rand_weight();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 20)) - 10;
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return -$signed({1'b0, 31'($urandom_range(0, 32'h0004ffff))});
      endcase
   endfunction

   // fill the command queue: directed part, then phases of random commands
   initial begin
      command_type c;
      int n;
      int lim;
      add_cmd(make_cmd(mpc_pkg::ACT_READ, 0, 0, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_READ, 15, 0, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 0, 1, 32'sh7fffffff));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 1, 2, 32'sh7fffffff));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 2, 3, 32'sh7fffffff));
      add_cmd(make_cmd(mpc_pkg::ACT_READ, 0, 3, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 0, 1, 32'sh00000001));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 3, 0, -32'sd5));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 3, 0, 32'sh80000000));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 5, 5, '0));
      add_cmd(make_cmd(ACT_SPARE, 15, 15, 32'shffffffff));
      add_cmd(make_cmd(mpc_pkg::ACT_CLEAR, 0, 0, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 4, 6, 32'sh80000000));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 6, 4, 32'sh80000000));
      add_cmd(make_cmd(mpc_pkg::ACT_READ, 4, 4, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_READ, 6, 4, '0));
      add_cmd(make_cfg(16'hffff));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 7, 8, -32'sd65535));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 8, 7, 32'sd65535));
      add_cmd(make_cfg(16'h0000));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 8, 9, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 9, 8, '0));
      add_cmd(make_cmd(mpc_pkg::ACT_EDGE, 9, 8, 32'sd1));
      n = 0;
      while (n < RANDOM_CMDS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: add_cmd(make_cfg(16'h0000));
               1: add_cmd(make_cfg(16'hffff));
               default: add_cmd(make_cfg(mpc_pkg::TOL_W'($urandom)));
            endcase
         end
         add_cmd(make_cmd(mpc_pkg::ACT_CLEAR, $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom));
         n++;
         // mostly edges and reads within a chosen subset of nodes
         lim = $urandom_range(20, 120);
         for (int k = 0; k < lim; k++) begin
            c = make_cmd(mpc_pkg::ACT_EDGE, $urandom_range(0, 15),
                         $urandom_range(0, 15), rand_weight());
            case ($urandom_range(0, 19))
               0: c.action = mpc_pkg::ACT_CLEAR;
               1: c.action = ACT_SPARE;
               2, 3, 4, 5, 6, 7: c.action = mpc_pkg::ACT_READ;
               default: ;
            endcase
            if ($urandom_range(0, 3) != 0) begin
               c.from_node = $urandom_range(0, 5);
               c.to_node   = $urandom_range(0, 5);
            end
            add_cmd(c);
            n++;
         end
      end
      stimulus_done = 1'b1;
   end

   // sender: bursts and gaps; config writes and drain pauses hold until idle
   int  burst_left = 0;
   int  gap_left = 0;
   int  settle_left = 0;
   bit  accepted;

   always @(negedge clock) begin
      logic go;
      go = 1'b0;
      csr_wr_en <= 1'b0;
      if (!reset && !(start && !accepted)) begin
         if (pending_cmds.size() == 0) begin
            start <= 1'b0;
         end else if (pending_cmds[0].drain) begin
            start <= 1'b0;
            if (expected_rsps.size() != 0 || busy) settle_left = 40;
            else if (settle_left > 0) settle_left--;
            else begin
               if (pending_cmds[0].is_cfg) begin
                  csr_wr_en   <= 1'b1;
                  csr_wr_data <= pending_cmds[0].cfg_value;
               end
               void'(pending_cmds.pop_front());
            end
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 8);
               if ($urandom_range(0, 2) == 0) begin
                  gap_left = $urandom_range(1, 40);
                  start <= 1'b0;
               end
            end
            if (gap_left == 0) begin
               go = 1'b1;
               burst_left--;
            end
         end
      end
      if (go) begin
         start <= 1'b1;
         req_action      <= pending_cmds[0].action;
         req_from_node   <= pending_cmds[0].from_node;
         req_to_node     <= pending_cmds[0].to_node;
         req_edge_weight <= pending_cmds[0].weight;
      end
   end

   // accept a command transfer and predict its response; apply config writes
   always @(posedge clock) begin
      if (reset) begin
         accepted    <= 1'b0;
         idle_cycles <= 0;
         tol_now     <= mpc_pkg::TOL_W'(1);
         restore_identity();
      end else begin
         if (csr_wr_en) tol_now <= csr_wr_data;
         if (start && !busy) begin
            expected_rsps = {expected_rsps, closure_response(pending_cmds.pop_front())};
            accepted    <= 1'b1;
            idle_cycles <= 0;
         end else begin
            accepted <= 1'b0;
            if (rsp_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // check every response transfer against the oldest prediction
   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d value %0d", rsp_status,
                        rsp_path_value);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_path_value !== e.value
                || rsp_path_known !== e.known || rsp_saturated !== e.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status %0d/%0d value %0d/%0d known %0d/%0d sat %0d/%0d",
                           e.status, rsp_status, e.value, rsp_path_value,
                           e.known, rsp_path_known, e.saturated, rsp_saturated);
            end
         end
      end
   end

   // reset, then wait for drain and report
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (stimulus_done && pending_cmds.size() == 0 && !start
            && expected_rsps.size() == 0);
      repeat (2 * mpc_pkg::NODE_COUNT + 8) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("max_plus_closure_edge_insert_unit test passed");
      else
         $display("max_plus_closure_edge_insert_unit test failed");
      $finish;
   end

   // stop a hung run
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("max_plus_closure_edge_insert_unit test failed");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
rtl/mpc_pkg.sv
rtl/mpc_row_cell.sv
rtl/max_plus_closure_edge_insert_unit.sv
sim/max_plus_closure_edge_insert_unit_tb.sv
